/* src/bba_pkg.sv */
`default_nettype none

package bba_pkg;

	localparam int WORD_W  = 64;
	localparam int WORD_LG = 6;
	localparam int REQ_W   = 2;
	localparam int IDX_W   = 10;
	localparam int RES_W   = 10;
	localparam int COUNT_W = 11;
	localparam int STAT_W  = 2;

	localparam logic [COUNT_W-1:0] COUNT_MAX      = '1;
	localparam logic [RES_W-1:0]   RESERVED_RESET = 10'd10;

	localparam logic [REQ_W-1:0] REQ_ALLOC  = 2'd0;
	localparam logic [REQ_W-1:0] REQ_FREE   = 2'd1;
	localparam logic [REQ_W-1:0] REQ_FORMAT = 2'd2;

	localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
	localparam logic [STAT_W-1:0] STAT_NOFREE  = 2'd1;
	localparam logic [STAT_W-1:0] STAT_RANGE   = 2'd2;
	localparam logic [STAT_W-1:0] STAT_ISFREE  = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_SCAN,
		ST_FCHK,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic               found;
		logic [WORD_LG-1:0] bit_idx;
	} find_t;

endpackage

`default_nettype wire

/* src/bba_find.sv */
`default_nettype none

module bba_find
	import bba_pkg::*;
(
	input  wire logic [WORD_W-1:0] avail,
	output find_t                  res
);

	logic [WORD_W-1:0] lowest;

	always_comb begin
		lowest      = avail & (~avail + WORD_W'(1));
		res.found   = |avail;
		res.bit_idx = '0;
		for (int i = 0; i < WORD_W; i++) begin
			if (lowest[i]) begin
				res.bit_idx = res.bit_idx | WORD_LG'(i);
			end
		end
	end

endmodule

`default_nettype wire

/* src/bitmap_block_allocator.sv */
// First-fit block allocator over a one-bit-per-block usage map.
// Input channel (in_valid/in_ready) carries one request per beat: allocate,
// free or format. Output channel (out_valid/out_ready) returns one beat per
// request with the status, the granted block and the free count afterwards.
// The reserved-block register is written through cfg_wr_en/cfg_wr_data and
// takes effect for bounds at once and for the map at the next format.
// The map sits in a memory of 64-bit words with a registered read. An
// allocate reads one word per cycle from the word holding the reserved
// boundary upward until it finds a free bit or reaches the last word. A
// free reads and rewrites the word holding the block.
// One request is worked on at a time; the next is accepted as soon as the
// previous result has moved into the output register, even if the receiver
// has not yet taken it. When the receiver stalls, the output register holds
// and a finished result waits inside, so input stalls after one more beat.
// Format and reset clear the per-word valid bits, so an unwritten word
// reads as the reserved pattern of the last format.
// After reset the reserved count is 10 and the free count is total minus 10.

`default_nettype none

module bitmap_block_allocator
	import bba_pkg::*;
#(
	parameter int NUM_BLOCKS = 1024
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [REQ_W-1:0]   req_type,
	input  wire logic [IDX_W-1:0]   block_index,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [STAT_W-1:0]       status,
	output logic [RES_W-1:0]        alloc_block,
	output logic [COUNT_W-1:0]      free_count,
	input  wire logic               cfg_wr_en,
	input  wire logic [RES_W-1:0]   cfg_wr_data
);

	localparam int NW  = (NUM_BLOCKS + WORD_W - 1) / WORD_W;
	localparam int AW  = (NW > 1) ? $clog2(NW) : 1;
	localparam int NBW = $clog2(NUM_BLOCKS + 1);
	localparam int XW  = ((NBW > RES_W) ? NBW : RES_W) + 1;

	localparam logic [XW-1:0] NUM_X = XW'(NUM_BLOCKS);
	localparam logic [XW-1:0] RESET_LIM =
		(XW'(RESERVED_RESET) > NUM_X) ? NUM_X : XW'(RESERVED_RESET);

	function automatic logic [WORD_W-1:0] below_mask(input logic [XW-1:0] base,
		input logic [XW-1:0] lim);
		logic [XW-1:0]     d;
		logic [WORD_W-1:0] m;
		if (lim <= base) begin
			m = '0;
		end else begin
			d = lim - base;
			if (d >= XW'(WORD_W)) begin
				m = '1;
			end else begin
				m = ~({WORD_W{1'b1}} << d[WORD_LG-1:0]);
			end
		end
		return m;
	endfunction

	state_t state_q, state_d;

	logic [RES_W-1:0]   reserved_q;
	logic [COUNT_W-1:0] count_q, count_d;
	logic [NW-1:0]      valid_q;
	logic [XW-1:0]      fmt_lim_q;
	logic               fmt_go;

	logic [REQ_W-1:0]   req_q;
	logic [IDX_W-1:0]   blk_q;

	logic [WORD_W-1:0] mem [NW];
	logic [WORD_W-1:0] mem_rd_s1;
	logic [AW-1:0]     w_s1, w_d;
	logic              rd_en, wr_en;
	logic [AW-1:0]     rd_addr;
	logic [WORD_W-1:0] wr_data;

	logic [STAT_W-1:0] res_status_q, res_status_d;
	logic [RES_W-1:0]  res_alloc_q, res_alloc_d;
	logic              res_ld, out_ld;

	logic [XW-1:0]     res_x, blk_x, base, lim;
	logic [WORD_W-1:0] eff, avail;
	find_t             fres;
	logic              last_w;

	assign in_ready = (state_q == ST_IDLE);
	assign res_x    = XW'(reserved_q);
	assign blk_x    = XW'(blk_q);
	assign base     = XW'(w_s1) << WORD_LG;
	assign lim      = (res_x > NUM_X) ? NUM_X : res_x;
	assign last_w   = (w_s1 == AW'(NW - 1));
	assign eff      = valid_q[w_s1] ? mem_rd_s1 : below_mask(base, fmt_lim_q);
	assign avail    = ~eff & ~below_mask(base, res_x) & below_mask(base, NUM_X);

	bba_find u_find (
		.avail (avail),
		.res   (fres)
	);

	always_comb begin
		state_d      = state_q;
		count_d      = count_q;
		w_d          = w_s1;
		rd_en        = 1'b0;
		rd_addr      = w_s1 + AW'(1);
		wr_en        = 1'b0;
		wr_data      = eff;
		fmt_go       = 1'b0;
		res_ld       = 1'b0;
		res_status_d = STAT_OK;
		res_alloc_d  = '0;
		out_ld       = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_START;
				end
			end
			ST_START: begin
				case (req_q)
					REQ_ALLOC: begin
						if (res_x >= NUM_X) begin
							res_ld       = 1'b1;
							res_status_d = STAT_NOFREE;
							state_d      = ST_DONE;
						end else begin
							rd_en   = 1'b1;
							rd_addr = AW'(res_x >> WORD_LG);
							w_d     = AW'(res_x >> WORD_LG);
							state_d = ST_SCAN;
						end
					end
					REQ_FREE: begin
						if (blk_x < res_x || blk_x >= NUM_X) begin
							res_ld       = 1'b1;
							res_status_d = STAT_RANGE;
							state_d      = ST_DONE;
						end else begin
							rd_en   = 1'b1;
							rd_addr = AW'(blk_x >> WORD_LG);
							w_d     = AW'(blk_x >> WORD_LG);
							state_d = ST_FCHK;
						end
					end
					REQ_FORMAT: begin
						fmt_go  = 1'b1;
						count_d = COUNT_W'(NUM_X - lim);
						res_ld  = 1'b1;
						state_d = ST_DONE;
					end
					default: begin
						res_ld  = 1'b1;
						state_d = ST_DONE;
					end
				endcase
			end
			ST_SCAN: begin
				if (fres.found) begin
					wr_en       = 1'b1;
					wr_data     = eff | (WORD_W'(1) << fres.bit_idx);
					res_ld      = 1'b1;
					res_alloc_d = RES_W'(base + XW'(fres.bit_idx));
					if (count_q != '0) begin
						count_d = count_q - COUNT_W'(1);
					end
					state_d = ST_DONE;
				end else if (last_w) begin
					res_ld       = 1'b1;
					res_status_d = STAT_NOFREE;
					state_d      = ST_DONE;
				end else begin
					rd_en   = 1'b1;
					w_d     = w_s1 + AW'(1);
				end
			end
			ST_FCHK: begin
				res_ld = 1'b1;
				if (!eff[blk_q[WORD_LG-1:0]]) begin
					res_status_d = STAT_ISFREE;
				end else begin
					wr_en   = 1'b1;
					wr_data = eff & ~(WORD_W'(1) << blk_q[WORD_LG-1:0]);
					if (count_q != COUNT_MAX) begin
						count_d = count_q + COUNT_W'(1);
					end
				end
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid || out_ready) begin
					out_ld  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			reserved_q <= RESERVED_RESET;
			count_q    <= COUNT_W'(NUM_X - RESET_LIM);
			valid_q    <= '0;
			fmt_lim_q  <= RESET_LIM;
			out_valid  <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (cfg_wr_en) begin
				reserved_q <= cfg_wr_data;
			end
			if (fmt_go) begin
				valid_q   <= '0;
				fmt_lim_q <= lim;
			end else if (wr_en) begin
				valid_q[w_s1] <= 1'b1;
			end
			if (out_ld) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_q <= req_type;
			blk_q <= block_index;
		end
		w_s1 <= w_d;
		if (res_ld) begin
			res_status_q <= res_status_d;
			res_alloc_q  <= res_alloc_d;
		end
		if (out_ld) begin
			status      <= res_status_q;
			alloc_block <= res_alloc_q;
			free_count  <= count_q;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			mem_rd_s1 <= mem[rd_addr];
		end
		if (wr_en) begin
			mem[w_s1] <= wr_data;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (state_q == ST_SCAN || state_q == ST_FCHK))
		else $error("Map written outside a read-modify-write state.");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_START && req_q == REQ_FORMAT) |=> (valid_q == '0))
		else $error("Format did not invalidate the map words.");

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == STAT_OK && alloc_block != '0 && NUM_BLOCKS <= 1024)
		|-> (alloc_block >= reserved_q))
		else $error("Granted block lies in the reserved area.");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && out_valid && !out_ready) |=> (state_q == ST_DONE))
		else $error("Result left the done state while the output was stalled.");

endmodule

`default_nettype wire
